[src/bft_pkg.sv]
// shared constants, command and status codes, and control structs for the flow table
// no dependencies
package bft_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int KEY_W = 96;
    localparam int PKT_W = 32;
    localparam int BYTE_W = 48;
    localparam int CNT_W = PKT_W + BYTE_W;
    localparam int ID_W = 32;
    localparam int IN_DATA_W = 120;
    localparam int OUT_DATA_W = 120;

    localparam logic [2:0] CMD_OPEN = 3'd0;
    localparam logic [2:0] CMD_LOOKUP = 3'd1;
    localparam logic [2:0] CMD_CLOSE = 3'd2;
    localparam logic [2:0] CMD_DROP = 3'd3;
    localparam logic [2:0] CMD_UPDATE = 3'd4;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_EXISTS = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_DROPPED = 3'd4;

    typedef struct packed {
        logic load;
        logic cmp;
        logic sel;
        logic exec;
    } bft_ctrl_t;

    typedef struct packed {
        logic out_free;
    } bft_stat_t;

    function automatic logic [IDX_W-1:0] lowest_idx(input logic [ENTRIES-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[src/bft_ram.sv]
// generic simple dual-port ram (one write port, one read port) with registered read
// no dependencies
module bft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/bft_ctrl.sv]
// command sequencer: accept, compare, select, execute
// depends on bft_pkg
module bft_ctrl import bft_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  bft_stat_t stat,
    output bft_ctrl_t ctrl
);

    typedef enum logic [1:0] {IDLE, CMP, SEL, EXEC} state_t;

    state_t state_reg, state_next;

    always_comb begin
        ctrl.load = (state_reg == IDLE) && s_tvalid;
        ctrl.cmp = (state_reg == CMP);
        ctrl.sel = (state_reg == SEL);
        ctrl.exec = (state_reg == EXEC) && stat.out_free;
        state_next = state_reg;
        unique case (state_reg)
            IDLE: if (s_tvalid) state_next = CMP;
            CMP: state_next = SEL;
            SEL: state_next = EXEC;
            EXEC: if (stat.out_free) state_next = IDLE;
            default: state_next = IDLE;
        endcase
    end

    assign s_tready = (state_reg == IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_load_to_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load |=> state_reg == CMP) else $error("load not followed by compare");
    a_sel_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.sel |=> state_reg == EXEC) else $error("select not followed by execute");
    a_exec_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.exec |=> s_tready) else $error("not ready after execute");

endmodule

[src/bft_dp.sv]
// datapath: key store, parallel compare, slot select, id and counter rams, result register
// depends on bft_pkg and bft_ram
module bft_dp import bft_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bft_ctrl_t             ctrl,
    output bft_stat_t             stat,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [2:0]            m_tuser
);

    logic [2:0]         cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic               sd_reg;
    logic [15:0]        size_reg;
    logic [KEY_W-1:0]   slot_key_reg [ENTRIES];
    logic [ENTRIES-1:0] slot_valid_reg, slot_valid_next;
    logic [ENTRIES-1:0] slot_dropped_reg, slot_dropped_next;
    logic [ENTRIES-1:0] fwd_reg, rev_reg;
    logic [ID_W-1:0]    last_id_reg;
    logic [IDX_W-1:0]   slot_idx_reg, free_idx_reg;
    logic               found_reg, dir_reg, mdrop_reg, full_reg;
    logic               m_valid_reg;
    logic [2:0]         o_status_reg;
    logic               o_dir_reg, o_drop_reg;
    logic [ID_W-1:0]    o_id_reg;
    logic [PKT_W-1:0]   o_pkt_reg;
    logic [BYTE_W-1:0]  o_byte_reg;

    logic [KEY_W-1:0]   key_swap;
    logic [ENTRIES-1:0] chosen, chosen_oh, free_vec;
    logic [IDX_W-1:0]   sel_idx;
    logic [ID_W-1:0]    id_rdata;
    logic [CNT_W-1:0]   cnt0_rdata, cnt1_rdata, cnt_sel;
    logic [PKT_W-1:0]   pkt_new;
    logic [BYTE_W-1:0]  byte_new;
    logic               id_we, cnt0_we, cnt1_we, alloc;
    logic [IDX_W-1:0]   ram_waddr;
    logic [CNT_W-1:0]   cnt_wdata;
    logic [2:0]         st_next;
    logic               dir_out, drop_out;
    logic [ID_W-1:0]    id_out;
    logic [PKT_W-1:0]   pkt_out;
    logic [BYTE_W-1:0]  byte_out;

    assign key_swap = {key_reg[79:64], key_reg[95:80], key_reg[31:0], key_reg[63:32]};
    assign chosen = (|fwd_reg) ? fwd_reg : rev_reg;
    assign chosen_oh = chosen & (~chosen + 1'b1);
    assign sel_idx = lowest_idx(chosen);
    assign free_vec = ~slot_valid_reg | (chosen_oh & slot_dropped_reg);
    assign stat.out_free = !m_valid_reg || m_tready;

    assign cnt_sel = sd_reg ? cnt1_rdata : cnt0_rdata;
    assign pkt_new = cnt_sel[PKT_W-1:0] + 1'b1;
    assign byte_new = cnt_sel[CNT_W-1:PKT_W] + BYTE_W'(size_reg);
    assign alloc = (cmd_reg == CMD_OPEN) && !(found_reg && !mdrop_reg) && !full_reg;

    always_comb begin
        slot_valid_next = slot_valid_reg;
        slot_dropped_next = slot_dropped_reg;
        id_we = 1'b0;
        cnt0_we = 1'b0;
        cnt1_we = 1'b0;
        ram_waddr = slot_idx_reg;
        cnt_wdata = {byte_new, pkt_new};
        st_next = ST_OK;
        dir_out = dir_reg;
        drop_out = mdrop_reg;
        id_out = id_rdata;
        pkt_out = cnt_sel[PKT_W-1:0];
        byte_out = cnt_sel[CNT_W-1:PKT_W];
        if (cmd_reg > CMD_UPDATE) begin
            dir_out = 1'b0;
            drop_out = 1'b0;
            id_out = '0;
            pkt_out = '0;
            byte_out = '0;
        end else if (cmd_reg == CMD_OPEN) begin
            if (found_reg && !mdrop_reg) begin
                st_next = ST_EXISTS;
            end else if (full_reg) begin
                st_next = ST_FULL;
                dir_out = 1'b0;
                drop_out = 1'b0;
                id_out = '0;
                pkt_out = '0;
                byte_out = '0;
            end else begin
                if (found_reg) begin
                    slot_valid_next[slot_idx_reg] = 1'b0;
                    slot_dropped_next[slot_idx_reg] = 1'b0;
                end
                slot_valid_next[free_idx_reg] = 1'b1;
                slot_dropped_next[free_idx_reg] = 1'b0;
                ram_waddr = free_idx_reg;
                cnt_wdata = '0;
                id_we = 1'b1;
                cnt0_we = 1'b1;
                cnt1_we = 1'b1;
                dir_out = 1'b0;
                drop_out = 1'b0;
                id_out = last_id_reg + 1'b1;
                pkt_out = '0;
                byte_out = '0;
            end
        end else if (!found_reg) begin
            st_next = ST_NOT_FOUND;
            dir_out = 1'b0;
            drop_out = 1'b0;
            id_out = '0;
            pkt_out = '0;
            byte_out = '0;
        end else begin
            unique case (cmd_reg)
                CMD_LOOKUP: st_next = mdrop_reg ? ST_DROPPED : ST_OK;
                CMD_CLOSE: begin
                    slot_valid_next[slot_idx_reg] = 1'b0;
                    slot_dropped_next[slot_idx_reg] = 1'b0;
                end
                CMD_DROP: begin
                    slot_dropped_next[slot_idx_reg] = 1'b1;
                    drop_out = 1'b1;
                end
                default: begin
                    cnt0_we = !sd_reg;
                    cnt1_we = sd_reg;
                    pkt_out = pkt_new;
                    byte_out = byte_new;
                end
            endcase
        end
    end

    bft_ram #(.WIDTH(ID_W), .DEPTH(ENTRIES)) u_id_ram (
        .aclk(aclk), .we(ctrl.exec && id_we), .waddr(ram_waddr),
        .wdata(last_id_reg + 1'b1), .re(ctrl.sel), .raddr(sel_idx), .rdata(id_rdata)
    );
    bft_ram #(.WIDTH(CNT_W), .DEPTH(ENTRIES)) u_cnt0_ram (
        .aclk(aclk), .we(ctrl.exec && cnt0_we), .waddr(ram_waddr),
        .wdata(cnt_wdata), .re(ctrl.sel), .raddr(sel_idx), .rdata(cnt0_rdata)
    );
    bft_ram #(.WIDTH(CNT_W), .DEPTH(ENTRIES)) u_cnt1_ram (
        .aclk(aclk), .we(ctrl.exec && cnt1_we), .waddr(ram_waddr),
        .wdata(cnt_wdata), .re(ctrl.sel), .raddr(sel_idx), .rdata(cnt1_rdata)
    );

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg <= s_tuser;
            key_reg <= s_tdata[95:0];
            sd_reg <= s_tdata[96];
            size_reg <= s_tdata[112:97];
        end
        if (ctrl.cmp) begin
            for (int i = 0; i < ENTRIES; i++) begin
                fwd_reg[i] <= slot_valid_reg[i] && (slot_key_reg[i] == key_reg);
                rev_reg[i] <= slot_valid_reg[i] && (slot_key_reg[i] == key_swap);
            end
        end
        if (ctrl.sel) begin
            found_reg <= |chosen;
            dir_reg <= !(|fwd_reg) && (|rev_reg);
            mdrop_reg <= |(chosen_oh & slot_dropped_reg);
            slot_idx_reg <= sel_idx;
            free_idx_reg <= lowest_idx(free_vec);
            full_reg <= !(|free_vec);
        end
        if (ctrl.exec) begin
            if (alloc) begin
                slot_key_reg[free_idx_reg] <= key_reg;
            end
            o_status_reg <= st_next;
            o_dir_reg <= dir_out;
            o_drop_reg <= drop_out;
            o_id_reg <= id_out;
            o_pkt_reg <= pkt_out;
            o_byte_reg <= byte_out;
        end
        if (!aresetn) begin
            slot_valid_reg <= '0;
            slot_dropped_reg <= '0;
            last_id_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctrl.exec) begin
                slot_valid_reg <= slot_valid_next;
                slot_dropped_reg <= slot_dropped_next;
                if (alloc) begin
                    last_id_reg <= last_id_reg + 1'b1;
                end
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser = o_status_reg;
    assign m_tdata = {6'd0, o_byte_reg, o_pkt_reg, o_id_reg, o_drop_reg, o_dir_reg};

    a_drop_in_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (slot_dropped_reg & ~slot_valid_reg) == '0) else $error("dropped mark on free slot");
    a_alloc_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.exec && alloc |=> slot_valid_reg[$past(free_idx_reg)])
        else $error("allocated slot not valid");
    a_id_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.exec && !alloc |=> $stable(last_id_reg)) else $error("id moved without open");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.exec |-> !m_valid_reg || m_tready) else $error("result overwritten");

endmodule

[src/bidirectional_flow_table.sv]
// top level of the bidirectional connection table
// depends on bft_pkg, bft_ctrl, bft_dp and bft_ram
//
// usage:
//   slave channel s_* carries one command item: s_tuser holds cmd, s_tdata the key,
//   stat_direction and packet_size. master channel m_* returns one result item per
//   command: m_tuser holds status, m_tdata the match and counter fields.
//   commands are open, lookup, close, drop and update; every command yields one result.
// processing:
//   an item passes from accept to result valid through compare of all slots in both
//   orientations, priority select of the slot together with the registered ram read of
//   id and counters, then execute with write-back. one item is in work at a time and
//   s_tready returns in the cycle after execute; the accept of the next item overlaps
//   the wait of the result register.
// reset:
//   aresetn low clears all valid and dropped marks and the id counter; the table
//   is empty right after reset, no clearing pass
// stall:
//   a result held in the output register waits for m_tready; a new item is taken
//   meanwhile and waits in execute until the output register is free
module bidirectional_flow_table import bft_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // src_ip, dst_ip, src_port, dst_port, stat_direction, packet_size
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // cmd
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // direction, entry_dropped, conn_id, packet_total, byte_total
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status
    output logic [2:0]            m_tuser
);

    bft_ctrl_t ctrl;
    bft_stat_t stat;

    bft_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .stat(stat), .ctrl(ctrl)
    );

    bft_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .stat(stat),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

endmodule

[tb/testbench.sv]
// self-checking testbench for bidirectional_flow_table: directed and random command items with a
// predictor class and a scoreboard of expected result items
// depends on bft_pkg and the block's rtl
module testbench;
    import bft_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic        stat_dir;
        logic [15:0] pkt_size;
    } flow_cmd_t;

    typedef struct {
        logic [2:0]  status;
        logic        direction;
        logic        dropped;
        logic [31:0] conn_id;
        logic [31:0] pkt_total;
        logic [47:0] byte_total;
    } flow_result_t;

    class flow_scoreboard;
        bit          valid[ENTRIES];
        bit          dropped[ENTRIES];
        logic [95:0] key[ENTRIES];
        logic [31:0] id[ENTRIES];
        logic [31:0] pkts[2*ENTRIES];
        logic [47:0] bytes[2*ENTRIES];
        logic [31:0] last_id;
        flow_result_t pending[$];
        int errors;

        function new();
            foreach (valid[i]) begin
                valid[i] = 0;
                dropped[i] = 0;
            end
            last_id = '0;
            errors = 0;
        endfunction

        function flow_result_t slot_report(logic [2:0] st, logic d, int s, logic sd);
            flow_result_t r;
            r.status = st;
            r.direction = d;
            r.dropped = dropped[s];
            r.conn_id = id[s];
            r.pkt_total = pkts[2*s+sd];
            r.byte_total = bytes[2*s+sd];
            return r;
        endfunction

        function void note_command(flow_cmd_t c);
            flow_result_t r;
            logic [95:0] fwd, rev;
            int s, f, idx;
            logic d;
            r = '{default: '0};
            fwd = {c.src_ip, c.dst_ip, c.src_port, c.dst_port};
            rev = {c.dst_ip, c.src_ip, c.dst_port, c.src_port};
            s = -1;
            d = 0;
            if (c.cmd <= CMD_UPDATE) begin
                for (int i = 0; i < ENTRIES && s < 0; i++)
                    if (valid[i] && key[i] == fwd) s = i;
                for (int i = 0; i < ENTRIES && s < 0; i++)
                    if (valid[i] && key[i] == rev) begin
                        s = i;
                        d = 1;
                    end
                if (c.cmd == CMD_OPEN) begin
                    if (s >= 0 && !dropped[s]) begin
                        r = slot_report(ST_EXISTS, d, s, c.stat_dir);
                    end else begin
                        if (s >= 0) begin
                            valid[s] = 0;
                            dropped[s] = 0;
                        end
                        f = -1;
                        for (int i = 0; i < ENTRIES && f < 0; i++)
                            if (!valid[i]) f = i;
                        if (f < 0) begin
                            r.status = ST_FULL;
                        end else begin
                            last_id = last_id + 1;
                            valid[f] = 1;
                            dropped[f] = 0;
                            key[f] = fwd;
                            id[f] = last_id;
                            pkts[2*f] = 0;
                            pkts[2*f+1] = 0;
                            bytes[2*f] = 0;
                            bytes[2*f+1] = 0;
                            r = slot_report(ST_OK, 0, f, c.stat_dir);
                        end
                    end
                end else if (s < 0) begin
                    r.status = ST_NOT_FOUND;
                end else if (c.cmd == CMD_LOOKUP) begin
                    r = slot_report(dropped[s] ? ST_DROPPED : ST_OK, d, s, c.stat_dir);
                end else if (c.cmd == CMD_CLOSE) begin
                    r = slot_report(ST_OK, d, s, c.stat_dir);
                    valid[s] = 0;
                    dropped[s] = 0;
                end else if (c.cmd == CMD_DROP) begin
                    dropped[s] = 1;
                    r = slot_report(ST_OK, d, s, c.stat_dir);
                end else begin
                    idx = 2*s + c.stat_dir;
                    pkts[idx] = pkts[idx] + 1;
                    bytes[idx] = bytes[idx] + c.pkt_size;
                    r = slot_report(ST_OK, d, s, c.stat_dir);
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [2:0] st, logic [OUT_DATA_W-1:0] data);
            flow_result_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item status=%0d", st);
                return;
            end
            e = pending.pop_front();
            if (st !== e.status || data[0] !== e.direction || data[1] !== e.dropped ||
                data[33:2] !== e.conn_id || data[65:34] !== e.pkt_total ||
                data[113:66] !== e.byte_total || data[119:114] !== '0) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp st=%0d dir=%0d drp=%0d id=%0d pk=%0d by=%0d",
                              " got st=%0d dir=%0d drp=%0d id=%0d pk=%0d by=%0d"},
                             e.status, e.direction, e.dropped, e.conn_id, e.pkt_total,
                             e.byte_total, st, data[0], data[1], data[33:2], data[65:34],
                             data[113:66]);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [2:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [2:0]            m_tuser;

    bidirectional_flow_table dut (.*);

    flow_scoreboard board = new();
    int idle_pct;
    int stall_pct;
    bit hold_off;
    int quiet_cycles;
    logic [95:0] key_pool[80];

    initial aclk = 0;
    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        if (hold_off) m_tready <= 0;
        else m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tuser, m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic send(logic [2:0] cmd, logic [95:0] k, logic sd, logic [15:0] sz);
        flow_cmd_t c;
        c.cmd = cmd;
        {c.src_ip, c.dst_ip, c.src_port, c.dst_port} = k;
        c.stat_dir = sd;
        c.pkt_size = sz;
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {7'd0, sz, sd, c.dst_port, c.src_port, c.dst_ip, c.src_ip};
        do @(posedge aclk); while (!s_tready);
        board.note_command(c);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 0;
            s_tdata <= IN_DATA_W'({$urandom, $urandom, $urandom, $urandom});
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
            @(posedge aclk);
        end
    endtask

    function automatic logic [95:0] swap_key(logic [95:0] k);
        return {k[63:32], k[95:64], k[15:0], k[31:16]};
    endfunction

    task automatic random_item();
        logic [95:0] k;
        int w;
        logic [2:0] cmd;
        k = key_pool[$urandom_range(79)];
        if ($urandom_range(1)) k = swap_key(k);
        if ($urandom_range(19) == 0) k = {$urandom, $urandom, $urandom};
        w = $urandom_range(99);
        if (w < 30) cmd = CMD_OPEN;
        else if (w < 50) cmd = CMD_LOOKUP;
        else if (w < 62) cmd = CMD_CLOSE;
        else if (w < 72) cmd = CMD_DROP;
        else if (w < 97) cmd = CMD_UPDATE;
        else cmd = 3'($urandom_range(7, 5));
        send(cmd, k, $urandom_range(1), 16'($urandom));
    endtask

    initial begin
        logic [95:0] ka, kb;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 0;
        hold_off = 0;
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom, $urandom};
        key_pool[0] = '1;
        key_pool[1] = '0;
        key_pool[2] = {32'hffffffff, 32'h0, 16'hffff, 16'h0};
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        ka = key_pool[2];
        kb = key_pool[0];
        send(CMD_LOOKUP, ka, 0, 0);
        send(CMD_OPEN, ka, 0, 0);
        send(CMD_OPEN, ka, 1, 0);
        send(CMD_OPEN, swap_key(ka), 0, 0);
        send(CMD_LOOKUP, swap_key(ka), 1, 0);
        send(CMD_UPDATE, ka, 0, 16'hffff);
        send(CMD_UPDATE, swap_key(ka), 1, 16'hffff);
        send(CMD_UPDATE, ka, 1, 16'h0);
        send(CMD_LOOKUP, ka, 1, 0);
        send(CMD_OPEN, kb, 0, 0);
        send(CMD_DROP, kb, 1, 0);
        send(CMD_DROP, kb, 1, 0);
        send(CMD_LOOKUP, kb, 0, 0);
        send(CMD_UPDATE, kb, 0, 16'h1234);
        send(CMD_OPEN, kb, 0, 0);
        send(CMD_LOOKUP, kb, 0, 0);
        send(CMD_CLOSE, swap_key(ka), 0, 0);
        send(CMD_CLOSE, ka, 0, 0);
        send(CMD_DROP, ka, 0, 0);
        send(CMD_UPDATE, ka, 0, 1);
        send(3'd5, ka, 1, 16'hffff);
        send(3'd7, kb, 0, 0);
        send(3'd6, '1, 1, 16'hffff);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 33 : 45) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 33 : 45) : 0;
            if (ph == 2) fork
                begin
                    hold_off = 1;
                    repeat (300) @(posedge aclk);
                    hold_off = 0;
                end
            join_none
            repeat (460) random_item();
        end
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.errors == 0) $display("testbench: PASS");
        else $display("testbench: FAIL");
        $finish;
    end
endmodule

[files.f]
src/bft_pkg.sv
src/bft_ram.sv
src/bft_ctrl.sv
src/bft_dp.sv
src/bidirectional_flow_table.sv
tb/testbench.sv
